### rtl/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_W         = 5;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned WSEL_W        = 3;
  localparam int unsigned LINE_W        = 8;
  localparam int unsigned DEF_NUM_WORDS = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_EN  = 3'd0,
    KIND_CLR_EN  = 3'd1,
    KIND_SET_PD  = 3'd2,
    KIND_CLR_PD  = 3'd3,
    KIND_REQUEST = 3'd4,
    KIND_TAKE    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    UOP_SET,
    UOP_CLR,
    UOP_TAKE
  } unit_op_e;

  // result of one pass through the shared bit unit
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              test;
    logic              hit;
    logic [BIT_W-1:0]  idx;
  } unit_res_t;

endpackage

`default_nettype wire

### rtl/ipc_if.sv
`default_nettype none

interface ipc_in_if import ipc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WSEL_W-1:0] word_select;
  logic [WORD_W-1:0] write_mask;
  logic [LINE_W-1:0] line_number;

  modport source (output valid, kind, word_select, write_mask, line_number, input ready);
  modport sink   (input valid, kind, word_select, write_mask, line_number, output ready);
endinterface

interface ipc_out_if import ipc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              line_enabled;
  logic              found;
  logic [LINE_W-1:0] taken_line;

  modport source (output valid, line_enabled, found, taken_line, input ready);
  modport sink   (input valid, line_enabled, found, taken_line, output ready);
endinterface

`default_nettype wire

### rtl/ipc_word_store.sv
`default_nettype none

module ipc_word_store import ipc_pkg::*; #(
  parameter int unsigned NUM_WORDS = DEF_NUM_WORDS,
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [WORD_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [WORD_W-1:0] wr_data_i
);

  logic [WORD_W-1:0]    mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_q;
  logic [WORD_W-1:0]    rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // a word never written since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/ipc_bit_unit.sv
`default_nettype none

module ipc_bit_unit import ipc_pkg::*; (
  input  wire unit_op_e          op_i,
  input  wire logic [WORD_W-1:0] a_i,
  input  wire logic [WORD_W-1:0] b_i,
  input  wire logic [WORD_W-1:0] m_i,
  output unit_res_t              res_o
);

  logic [WORD_W-1:0] hit;
  logic [WORD_W-1:0] low;
  logic [BIT_W-1:0]  idx;

  assign hit = a_i & b_i;
  // isolate the lowest set bit
  assign low = hit & (~hit + WORD_W'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      idx = idx | (low[i] ? BIT_W'(i) : '0);
    end
  end

  always_comb begin
    res_o      = '0;
    res_o.test = |(b_i & m_i);
    res_o.hit  = |hit;
    res_o.idx  = idx;
    case (op_i)
      UOP_SET:  res_o.word = a_i | m_i;
      UOP_CLR:  res_o.word = a_i & ~m_i;
      UOP_TAKE: res_o.word = a_i & ~low;
      default:  res_o.word = a_i;
    endcase
  end

endmodule

`default_nettype wire

### rtl/interrupt_enable_pending_controller.sv
// Interrupt enable/pending controller.
// Holds one enable bit and one pending bit per interrupt line, NUM_WORDS words
// of 32 lines each, in two word stores with registered reads.
// in_i carries one transaction per operation: set/clear enable or pending
// bits of one word under a mask, a line request, or a take-next. out_o returns
// exactly one result transaction per input transaction.
// A write or request reads its word on acceptance, then modifies it and
// writes it back in S_EXEC and holds its result in S_OUT; a write to a word
// beyond NUM_WORDS, a request for such a line and a no-op kind go straight
// to S_OUT. A take-next scans the words through the shared bit unit one
// word per cycle, stops at the first hit, whose pending bit it clears, or
// after the last word, then holds its result in S_OUT. The block returns
// to idle before it accepts the next transaction.
// One transaction is worked on at a time; in_i.ready is high only in idle.
// A stalled out_o holds its result and keeps in_i.ready low until taken.
// Reset clears all enable and pending bits at once through per-word valid
// flags; the block is ready as soon as reset is released.
`default_nettype none

module interrupt_enable_pending_controller import ipc_pkg::*; #(
  parameter int unsigned NUM_WORDS = DEF_NUM_WORDS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ipc_in_if.sink      in_i,
  ipc_out_if.source   out_o
);

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);
  localparam logic [WSEL_W+1:0] NW_CMP = (WSEL_W + 2)'(NUM_WORDS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [WORD_W-1:0] mask_q, mask_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              enabled_q, enabled_d;
  logic              found_q, found_d;
  logic [LINE_W-1:0] taken_q, taken_d;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en_en;
  logic              wr_en_pd;
  logic [WORD_W-1:0] en_word;
  logic [WORD_W-1:0] pd_word;

  unit_op_e          u_op;
  logic [WORD_W-1:0] u_a;
  logic [WORD_W-1:0] u_b;
  logic [WORD_W-1:0] u_m;
  unit_res_t         u_res;

  logic accept;
  assign accept = in_i.valid && in_i.ready;

  ipc_word_store #(.NUM_WORDS(NUM_WORDS)) u_en_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (en_word),
    .wr_en_i   (wr_en_en),
    .wr_addr_i (addr_q),
    .wr_data_i (u_res.word)
  );

  ipc_word_store #(.NUM_WORDS(NUM_WORDS)) u_pd_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (pd_word),
    .wr_en_i   (wr_en_pd),
    .wr_addr_i (addr_q),
    .wr_data_i (u_res.word)
  );

  ipc_bit_unit u_unit (
    .op_i  (u_op),
    .a_i   (u_a),
    .b_i   (u_b),
    .m_i   (u_m),
    .res_o (u_res)
  );

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    mask_d    = mask_q;
    bit_d     = bit_q;
    addr_d    = addr_q;
    enabled_d = enabled_q;
    found_d   = found_q;
    taken_d   = taken_q;
    rd_en     = 1'b0;
    rd_addr   = addr_q;
    wr_en_en  = 1'b0;
    wr_en_pd  = 1'b0;
    u_op      = UOP_SET;
    u_a       = pd_word;
    u_b       = en_word;
    u_m       = mask_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d    = in_i.kind;
          mask_d    = in_i.write_mask;
          bit_d     = in_i.line_number[BIT_W-1:0];
          enabled_d = 1'b0;
          found_d   = 1'b0;
          taken_d   = '0;
          state_d   = S_OUT;
          case (in_i.kind)
            KIND_SET_EN, KIND_CLR_EN, KIND_SET_PD, KIND_CLR_PD: begin
              if ({2'b00, in_i.word_select} < NW_CMP) begin
                addr_d  = AW'(in_i.word_select);
                rd_addr = addr_d;
                rd_en   = 1'b1;
                state_d = S_EXEC;
              end
            end
            KIND_REQUEST: begin
              if ({2'b00, in_i.line_number[LINE_W-1:BIT_W]} < NW_CMP) begin
                addr_d  = AW'(in_i.line_number[LINE_W-1:BIT_W]);
                rd_addr = addr_d;
                rd_en   = 1'b1;
                state_d = S_EXEC;
              end
            end
            KIND_TAKE: begin
              addr_d  = '0;
              rd_addr = '0;
              rd_en   = 1'b1;
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_EXEC: begin
        state_d = S_OUT;
        case (kind_q)
          KIND_SET_EN: begin
            u_op     = UOP_SET;
            u_a      = en_word;
            wr_en_en = 1'b1;
          end
          KIND_CLR_EN: begin
            u_op     = UOP_CLR;
            u_a      = en_word;
            wr_en_en = 1'b1;
          end
          KIND_SET_PD: begin
            u_op     = UOP_SET;
            wr_en_pd = 1'b1;
          end
          KIND_CLR_PD: begin
            u_op     = UOP_CLR;
            wr_en_pd = 1'b1;
          end
          KIND_REQUEST: begin
            u_op      = UOP_SET;
            u_m       = WORD_W'(1) << bit_q;
            wr_en_pd  = 1'b1;
            enabled_d = u_res.test;
          end
          default: begin
            u_op = UOP_SET;
          end
        endcase
      end

      S_SCAN: begin
        // examine word addr_q; on a miss before the last word, prefetch the next one
        u_op = UOP_TAKE;
        if (u_res.hit) begin
          wr_en_pd = 1'b1;
          found_d  = 1'b1;
          taken_d  = LINE_W'({addr_q, u_res.idx});
          state_d  = S_OUT;
        end else if (addr_q == LAST_ADDR) begin
          state_d = S_OUT;
        end else begin
          addr_d  = addr_q + AW'(1);
          rd_addr = addr_d;
          rd_en   = 1'b1;
        end
      end

      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kind_q    <= '0;
      mask_q    <= '0;
      bit_q     <= '0;
      addr_q    <= '0;
      enabled_q <= 1'b0;
      found_q   <= 1'b0;
      taken_q   <= '0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      mask_q    <= mask_d;
      bit_q     <= bit_d;
      addr_q    <= addr_d;
      enabled_q <= enabled_d;
      found_q   <= found_d;
      taken_q   <= taken_d;
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = (state_q == S_OUT);
  assign out_o.line_enabled = enabled_q;
  assign out_o.found        = found_q;
  assign out_o.taken_line   = taken_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input accepted while a transaction is in flight");

  a_result_kinds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.found && out_o.line_enabled))
    else $error("result flags both request and take");

  a_write_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_en && wr_en_pd))
    else $error("both word stores written in one cycle");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= LAST_ADDR))
    else $error("scan address beyond last word");

  a_take_clears_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && wr_en_pd) |->
      (u_res.hit && u_res.word != pd_word))
    else $error("take wrote back without clearing a pending bit");

endmodule

`default_nettype wire

### tb/tb_top.sv
module tb_top;
  import ipc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_WORDS   = DEF_NUM_WORDS;
  localparam int unsigned RANDOM_OPS  = 1550;
  localparam int unsigned MAX_WAIT    = 16;
  localparam int unsigned DRAIN_EVERY = 300;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // kinds the block treats as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WSEL_W-1:0] word_select;
    logic [WORD_W-1:0] write_mask;
    logic [LINE_W-1:0] line_number;
    int unsigned       gap;
    bit                drain;
  } bus_op_t;

  typedef struct packed {
    logic              line_enabled;
    logic              found;
    logic [LINE_W-1:0] taken_line;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  ipc_in_if  req_if ();
  ipc_out_if rsp_if ();

  interrupt_enable_pending_controller #(
    .NUM_WORDS (NUM_WORDS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (rsp_if.source)
  );

  logic [WORD_W-1:0] en_words [NUM_WORDS];
  logic [WORD_W-1:0] pd_words [NUM_WORDS];

  bus_op_t     op_queue[$];
  outcome_t    outcome_queue[$];
  bus_op_t     next_op;
  bit          have_next;
  bit          in_fire;
  bit          out_fire;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned op_total;
  int unsigned accepted_cnt;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Update the enable/pending state for one transaction and return its result.
  function automatic outcome_t apply_op(input logic [KIND_W-1:0] kind,
                                        input logic [WSEL_W-1:0] wsel,
                                        input logic [WORD_W-1:0] mask,
                                        input logic [LINE_W-1:0] line);
    outcome_t          res;
    logic [WORD_W-1:0] hits;
    int unsigned       w;
    int unsigned       n;
    bit                done;
    res  = '0;
    done = 1'b0;
    case (kind)
      KIND_SET_EN: if (wsel < NUM_WORDS) en_words[wsel] = en_words[wsel] | mask;
      KIND_CLR_EN: if (wsel < NUM_WORDS) en_words[wsel] = en_words[wsel] & ~mask;
      KIND_SET_PD: if (wsel < NUM_WORDS) pd_words[wsel] = pd_words[wsel] | mask;
      KIND_CLR_PD: if (wsel < NUM_WORDS) pd_words[wsel] = pd_words[wsel] & ~mask;
      KIND_REQUEST: begin
        w = line >> BIT_W;
        if (w < NUM_WORDS) begin
          pd_words[w][line[BIT_W-1:0]] = 1'b1;
          res.line_enabled = en_words[w][line[BIT_W-1:0]];
        end
      end
      KIND_TAKE: begin
        for (w = 0; w < NUM_WORDS && !done; w++) begin
          hits = en_words[w] & pd_words[w];
          for (n = 0; n < WORD_W && !done; n++) begin
            if (hits[n]) begin
              pd_words[w][n]  = 1'b0;
              done            = 1'b1;
              res.found       = 1'b1;
              res.taken_line  = LINE_W'(w * WORD_W + n);
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_op(input logic [KIND_W-1:0] kind,
                                 input logic [WSEL_W-1:0] wsel,
                                 input logic [WORD_W-1:0] mask,
                                 input logic [LINE_W-1:0] line);
    bus_op_t op;
    op.kind        = kind;
    op.word_select = wsel;
    op.write_mask  = mask;
    op.line_number = line;
    // leave one stretch in five without sender gaps
    op.gap         = draw_wait(((op_queue.size() / 120) % 5) == 2);
    op.drain       = 1'b0;
    op_queue.push_back(op);
  endfunction

  function automatic logic [WORD_W-1:0] pick_mask();
    case ($urandom_range(0, 6))
      0:       return ALL_ONES;
      1:       return '0;
      2, 3:    return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      4:       return $urandom() & $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Sender: hold each transaction until accepted, then wait out the next gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || in_fire) begin
        in_fire = 1'b0;
        if (!have_next && op_queue.size() != 0) begin
          next_op   = op_queue.pop_front();
          have_next = 1'b1;
          gap_left  = next_op.gap;
        end
        if (have_next && gap_left == 0 &&
            !(next_op.drain && outcome_queue.size() != 0)) begin
          req_if.valid       <= 1'b1;
          req_if.kind        <= next_op.kind;
          req_if.word_select <= next_op.word_select;
          req_if.write_mask  <= next_op.write_mask;
          req_if.line_number <= next_op.line_number;
          have_next = 1'b0;
        end else begin
          if (gap_left > 0) gap_left--;
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: draw a stall after every result transaction.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        out_fire   = 1'b0;
        stall_left = draw_wait(((accepted_cnt / 128) % 4) == 1);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t exp_res;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        if (req_if.valid && req_if.ready) begin
          outcome_queue.push_back(apply_op(req_if.kind, req_if.word_select,
                                           req_if.write_mask, req_if.line_number));
          in_fire = 1'b1;
          accepted_cnt++;
        end
        if (rsp_if.valid && rsp_if.ready) begin
          out_fire = 1'b1;
          if (outcome_queue.size() == 0) begin
            $error("result transaction with no expectation pending");
            mismatch_cnt++;
          end else begin
            exp_res = outcome_queue.pop_front();
            if (rsp_if.line_enabled !== exp_res.line_enabled) begin
              $error("line_enabled: expected %0d, got %0d",
                     exp_res.line_enabled, rsp_if.line_enabled);
              mismatch_cnt++;
            end
            if (rsp_if.found !== exp_res.found) begin
              $error("found: expected %0d, got %0d", exp_res.found, rsp_if.found);
              mismatch_cnt++;
            end
            if (rsp_if.taken_line !== exp_res.taken_line) begin
              $error("taken_line: expected %0d, got %0d",
                     exp_res.taken_line, rsp_if.taken_line);
              mismatch_cnt++;
            end
          end
        end
      end
    end
  end

  initial begin
    int unsigned      live_ops;
    int unsigned      pick;
    logic [KIND_W-1:0] kind;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.kind        = KIND_SET_EN;
    req_if.word_select = '0;
    req_if.write_mask  = '0;
    req_if.line_number = '0;
    rsp_if.ready       = 1'b0;
    have_next          = 1'b0;
    in_fire            = 1'b0;
    out_fire           = 1'b0;
    gap_left           = 0;
    stall_left         = 0;
    accepted_cnt       = 0;
    cycle_cnt          = 0;
    mismatch_cnt       = 0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      en_words[w] = '0;
      pd_words[w] = '0;
    end

    // directed: empty take, edge lines, full words, no-op kinds
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_REQUEST, 3'd0, '0,           8'd0);
    add_op(KIND_REQUEST, 3'd0, '0,           8'd255);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_SET_EN,  3'd0, 32'h0000_0001, 8'd0);
    add_op(KIND_SET_EN,  3'd7, 32'h8000_0000, 8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_REQUEST, 3'd7, ALL_ONES,     8'd0);
    add_op(KIND_REQUEST, 3'd0, ALL_ONES,     8'd255);
    add_op(KIND_SET_PD,  3'd3, ALL_ONES,     8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_SET_EN,  3'd3, ALL_ONES,     8'd0);
    add_op(KIND_CLR_PD,  3'd3, 32'hAAAA_AAAA, 8'd0);
    add_op(KIND_CLR_EN,  3'd3, 32'h0000_FFFF, 8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_SPARE_A, 3'd7, ALL_ONES,     8'd255);
    add_op(KIND_SPARE_B, 3'd5, 32'h5555_5555, 8'd170);
    add_op(KIND_SET_PD,  3'd4, '0,           8'd0);
    add_op(KIND_CLR_EN,  3'd7, ALL_ONES,     8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);
    add_op(KIND_TAKE,    3'd0, '0,           8'd0);

    live_ops = 0;
    while (live_ops < RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      if      (pick < 12) kind = KIND_SET_EN;
      else if (pick < 20) kind = KIND_CLR_EN;
      else if (pick < 32) kind = KIND_SET_PD;
      else if (pick < 40) kind = KIND_CLR_PD;
      else if (pick < 66) kind = KIND_REQUEST;
      else if (pick < 96) kind = KIND_TAKE;
      else                kind = $urandom_range(0, 1) ? KIND_SPARE_B : KIND_SPARE_A;
      if (kind != KIND_SPARE_A && kind != KIND_SPARE_B) live_ops++;
      add_op(kind, $urandom_range(0, NUM_WORDS - 1), pick_mask(), $urandom_range(0, 255));
    end

    // hold the sender at a few points until every result is back
    for (int i = 20; i < op_queue.size(); i += DRAIN_EVERY) op_queue[i].drain = 1'b1;
    op_total = op_queue.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_cnt < op_total) @(posedge clk_i);
    while (outcome_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
